FILE: src/cpps_pkg.sv
package cpps_pkg;

    // core limit: requests are clamped to this count rounded up to a pair
    localparam int MAX_CORES = 8;
    localparam logic [3:0] CORE_LIM = 4'((MAX_CORES + 1) & ~1);

    localparam int PC_W = 5;

    // event modes
    localparam logic [2:0] MODE_STP_EN   = 3'd0;
    localparam logic [2:0] MODE_STP_DIS  = 3'd1;
    localparam logic [2:0] MODE_POOL_EN  = 3'd2;
    localparam logic [2:0] MODE_POOL_DIS = 3'd3;
    localparam logic [2:0] MODE_HOLD     = 3'd4;
    localparam logic [2:0] MODE_RELEASE  = 3'd5;

    // pool numbers owned by the io block
    localparam logic [3:0] UNIT_IO_LO = 4'd0;
    localparam logic [3:0] UNIT_IO_HI = 4'd15;

    // write targets
    localparam logic [2:0] T_STP_GATE  = 3'd0;
    localparam logic [2:0] T_POOL_GATE = 3'd1;
    localparam logic [2:0] T_GROUP     = 3'd2;
    localparam logic [2:0] T_PRE       = 3'd3;
    localparam logic [2:0] T_MAIN      = 3'd4;
    localparam logic [2:0] T_PAIRS     = 3'd5;
    localparam logic [2:0] T_RAM       = 3'd6;
    localparam logic [2:0] T_ISO       = 3'd7;

    // write actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // waits in microseconds
    localparam logic [6:0] WAIT_0   = 7'd0;
    localparam logic [6:0] WAIT_1   = 7'd1;
    localparam logic [6:0] WAIT_10  = 7'd10;
    localparam logic [6:0] WAIT_100 = 7'd100;

    // configuration register indexes
    localparam logic [1:0] CFG_CORE_COUNT = 2'd0;
    localparam logic [1:0] CFG_STAY_ON    = 2'd1;

    localparam logic [7:0] HOLD_MAX = 8'hFF;

    // microcode opcodes
    localparam logic [3:0] OP_END      = 4'd0;
    localparam logic [3:0] OP_DISPATCH = 4'd1;
    localparam logic [3:0] OP_UPCHK    = 4'd2;
    localparam logic [3:0] OP_DNCHK    = 4'd3;
    localparam logic [3:0] OP_WALK     = 4'd4;
    localparam logic [3:0] OP_EMIT     = 4'd5;
    localparam logic [3:0] OP_HOLD     = 4'd6;
    localparam logic [3:0] OP_RELEASE  = 4'd7;
    localparam logic [3:0] OP_SETWAIT  = 4'd8;

    // side effects on the loop registers
    localparam logic [1:0] UPD_NONE    = 2'd0;
    localparam logic [1:0] UPD_A_INC   = 2'd1;
    localparam logic [1:0] UPD_PWR_REQ = 2'd2;
    localparam logic [1:0] UPD_PWR_DN  = 2'd3;

    // branch kinds
    localparam logic [1:0] BR_NEXT    = 2'd0;
    localparam logic [1:0] BR_JUMP    = 2'd1;
    localparam logic [1:0] BR_LOOP_UP = 2'd2;
    localparam logic [1:0] BR_LOOP_DN = 2'd3;

    // value selects
    localparam logic [3:0] VS_ZERO      = 4'd0;
    localparam logic [3:0] VS_ACTM      = 4'd1;
    localparam logic [3:0] VS_ACTM_POOL = 4'd2;
    localparam logic [3:0] VS_M_A1      = 4'd3;
    localparam logic [3:0] VS_M_A2      = 4'd4;
    localparam logic [3:0] VS_PAIRS_A   = 4'd5;
    localparam logic [3:0] VS_M_NA      = 4'd6;
    localparam logic [3:0] VS_PAIRS_NA  = 4'd7;
    localparam logic [3:0] VS_PAIRS_NA1 = 4'd8;

    // program labels
    localparam logic [PC_W-1:0] L_DISP    = 5'd0;
    localparam logic [PC_W-1:0] L_UP      = 5'd1;
    localparam logic [PC_W-1:0] L_UP_LOOP = 5'd5;
    localparam logic [PC_W-1:0] L_WALK    = 5'd18;
    localparam logic [PC_W-1:0] L_DN_LOOP = 5'd21;
    localparam logic [PC_W-1:0] L_HOLD    = 5'd29;
    localparam logic [PC_W-1:0] L_REL     = 5'd30;
    localparam logic [PC_W-1:0] L_END     = 5'd31;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] unit_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  target;
        logic [1:0]  action;
        logic [12:0] value;
        logic [6:0]  wait_us;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [3:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      target;
        logic [1:0]      action;
        logic [3:0]      vsel;
        logic [6:0]      wait_us;
        logic [1:0]      upd;
        logic [1:0]      br;
        logic [PC_W-1:0] addr;
    } t_uword;

    typedef struct packed {
        logic   take_item;
        logic   fire;
        t_uword uw;
    } t_ctl;

    typedef struct packed {
        logic [PC_W-1:0] disp_addr;
        logic            skip;
        logic            walk_done;
        logic            loop_up;
        logic            loop_dn;
        logic            hold_zero;
        logic            hold_le1;
        logic [12:0]     value;
    } t_stat;

endpackage

FILE: src/cpps_stream_if.sv
interface cpps_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/cpps_ucode_rom.sv
module cpps_ucode_rom (
    input  logic [cpps_pkg::PC_W-1:0] i_addr,
    output cpps_pkg::t_uword          o_word
);
    import cpps_pkg::*;

    function automatic t_uword mk(
        input logic [3:0]      op,
        input logic [2:0]      tgt,
        input logic [1:0]      act,
        input logic [3:0]      vs,
        input logic [6:0]      wt,
        input logic [1:0]      upd,
        input logic [1:0]      br,
        input logic [PC_W-1:0] addr
    );
        t_uword w;
        w.op      = op;
        w.target  = tgt;
        w.action  = act;
        w.vsel    = vs;
        w.wait_us = wt;
        w.upd     = upd;
        w.br      = br;
        w.addr    = addr;
        return w;
    endfunction

    always_comb begin
        unique case (i_addr)
            // decode event, update marks
            5'd0:  o_word = mk(OP_DISPATCH, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            // power-up
            5'd1:  o_word = mk(OP_UPCHK, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd2:  o_word = mk(OP_EMIT, T_STP_GATE, ACT_WRITE, VS_ACTM, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd3:  o_word = mk(OP_EMIT, T_POOL_GATE, ACT_WRITE, VS_ACTM_POOL, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd4:  o_word = mk(OP_HOLD, T_GROUP, ACT_SET, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd5:  o_word = mk(OP_EMIT, T_PRE, ACT_WRITE, VS_M_A1, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd6:  o_word = mk(OP_EMIT, T_MAIN, ACT_WRITE, VS_M_A1, WAIT_10,
                               UPD_NONE, BR_NEXT, L_END);
            5'd7:  o_word = mk(OP_EMIT, T_PRE, ACT_WRITE, VS_M_A2, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd8:  o_word = mk(OP_EMIT, T_MAIN, ACT_WRITE, VS_M_A2, WAIT_10,
                               UPD_NONE, BR_NEXT, L_END);
            5'd9:  o_word = mk(OP_EMIT, T_PAIRS, ACT_WRITE, VS_PAIRS_A, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd10: o_word = mk(OP_EMIT, T_PAIRS, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd11: o_word = mk(OP_EMIT, T_RAM, ACT_WRITE, VS_M_A2, WAIT_1,
                               UPD_NONE, BR_NEXT, L_END);
            5'd12: o_word = mk(OP_EMIT, T_PAIRS, ACT_WRITE, VS_PAIRS_A, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd13: o_word = mk(OP_EMIT, T_ISO, ACT_WRITE, VS_M_A2, WAIT_0,
                               UPD_A_INC, BR_LOOP_UP, L_UP_LOOP);
            5'd14: o_word = mk(OP_SETWAIT, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd15: o_word = mk(OP_RELEASE, T_GROUP, ACT_CLEAR, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd16: o_word = mk(OP_EMIT, T_STP_GATE, ACT_CLEAR, VS_ACTM, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd17: o_word = mk(OP_EMIT, T_POOL_GATE, ACT_CLEAR, VS_ACTM_POOL, WAIT_0,
                               UPD_PWR_REQ, BR_JUMP, L_END);
            // power-down: search marks, then walk pairs down
            5'd18: o_word = mk(OP_WALK, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd19: o_word = mk(OP_DNCHK, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd20: o_word = mk(OP_HOLD, T_GROUP, ACT_SET, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd21: o_word = mk(OP_EMIT, T_ISO, ACT_WRITE, VS_M_NA, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd22: o_word = mk(OP_EMIT, T_PAIRS, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd23: o_word = mk(OP_EMIT, T_RAM, ACT_WRITE, VS_M_NA, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd24: o_word = mk(OP_EMIT, T_PAIRS, ACT_WRITE, VS_PAIRS_NA1, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd25: o_word = mk(OP_EMIT, T_PAIRS, ACT_WRITE, VS_PAIRS_NA, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd26: o_word = mk(OP_EMIT, T_MAIN, ACT_WRITE, VS_M_NA, WAIT_0,
                               UPD_PWR_DN, BR_LOOP_DN, L_DN_LOOP);
            5'd27: o_word = mk(OP_SETWAIT, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd28: o_word = mk(OP_RELEASE, T_GROUP, ACT_CLEAR, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_JUMP, L_END);
            // plain gating events
            5'd29: o_word = mk(OP_HOLD, T_GROUP, ACT_SET, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_JUMP, L_END);
            5'd30: o_word = mk(OP_RELEASE, T_GROUP, ACT_CLEAR, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            5'd31: o_word = mk(OP_END, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                               UPD_NONE, BR_NEXT, L_END);
            default: o_word = mk(OP_END, T_STP_GATE, ACT_WRITE, VS_ZERO, WAIT_0,
                                 UPD_NONE, BR_NEXT, L_END);
        endcase
    end
endmodule

FILE: src/cpps_datapath.sv
module cpps_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpps_pkg::t_in_item   i_item,
    input  cpps_pkg::t_ctl       i_ctl,
    input  logic                 i_cfg_we,
    input  cpps_pkg::t_cfg_item  i_cfg,
    output cpps_pkg::t_stat      o_stat
);
    import cpps_pkg::*;

    logic [3:0]  r_core_count;
    logic        r_stay_on;
    logic [3:0]  r_powered;
    logic [15:0] r_stp;
    logic [15:0] r_pool;
    logic [7:0]  r_hold;
    logic [2:0]  r_mode;
    logic [3:0]  r_id;
    logic [3:0]  r_req;
    logic [3:0]  r_a;
    logic [3:0]  r_r;

    logic [15:0] id_bit;
    logic        inner;
    logic [4:0]  req_raw;
    logic [3:0]  req_up;
    logic [4:0]  req_dn;
    logic [3:0]  na;
    logic [15:0] full_cc;
    logic [15:0] full_rq;
    logic [12:0] maxm;
    logic [12:0] actm;
    logic [3:0]  sh1;
    logic [3:0]  sh2;
    logic [12:0] sl1;
    logic [12:0] sl2;
    logic [12:0] sln;
    logic        is_op;
    t_uword      uw;

    assign uw    = i_ctl.uw;
    assign is_op = i_ctl.fire;

    assign id_bit  = 16'd1 << r_id;
    assign inner   = (r_id != UNIT_IO_LO) && (r_id != UNIT_IO_HI);
    assign req_raw = ({1'b0, r_id} + 5'd1) & ~5'd1;
    assign req_up  = (req_raw > {1'b0, CORE_LIM}) ? CORE_LIM : req_raw[3:0];
    assign req_dn  = ({1'b0, r_r} + 5'd1) & ~5'd1;
    assign na      = (r_powered >= 4'd2) ? r_powered - 4'd2 : 4'd0;

    assign full_cc = (16'd1 << r_core_count) - 16'd1;
    assign full_rq = (16'd1 << r_req) - 16'd1;
    assign maxm    = full_cc[12:0];
    assign actm    = full_rq[12:0];
    assign sh1     = r_a + 4'd1;
    assign sh2     = r_a + 4'd2;
    assign sl1     = maxm << sh1;
    assign sl2     = maxm << sh2;
    assign sln     = maxm << na;

    always_comb begin
        o_stat.hold_zero = (r_hold == 8'd0);
        o_stat.hold_le1  = (r_hold <= 8'd1);
        o_stat.walk_done = (r_r == 4'd0) || r_stp[r_r] || r_pool[r_r];
        o_stat.loop_up   = ({1'b0, r_a} + 5'd2) < {1'b0, r_req};
        o_stat.loop_dn   = na > r_req;

        unique case (uw.op)
            OP_UPCHK: o_stat.skip = (req_up <= r_powered);
            OP_DNCHK: o_stat.skip = (req_dn >= {1'b0, r_powered});
            default:  o_stat.skip = 1'b0;
        endcase

        unique case (r_mode)
            MODE_STP_EN:   o_stat.disp_addr = L_UP;
            MODE_STP_DIS:  o_stat.disp_addr = r_stay_on ? L_END : L_WALK;
            MODE_POOL_EN:  o_stat.disp_addr = inner ? L_UP : L_END;
            MODE_POOL_DIS: o_stat.disp_addr = (!r_stay_on && inner) ? L_WALK : L_END;
            MODE_HOLD:     o_stat.disp_addr = L_HOLD;
            MODE_RELEASE:  o_stat.disp_addr = L_REL;
            default:       o_stat.disp_addr = L_END;
        endcase

        unique case (uw.vsel)
            VS_ACTM:      o_stat.value = actm;
            VS_ACTM_POOL: o_stat.value = {actm[11:0], 1'b1};
            VS_M_A1:      o_stat.value = sl1 & maxm;
            VS_M_A2:      o_stat.value = sl2 & maxm;
            VS_PAIRS_A:   o_stat.value = {10'd0, r_a[3:1]};
            VS_M_NA:      o_stat.value = sln & maxm;
            VS_PAIRS_NA:  o_stat.value = {10'd0, na[3:1]};
            VS_PAIRS_NA1: o_stat.value = {10'd0, na[3:1]} + 13'd1;
            default:      o_stat.value = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count <= 4'd8;
            r_stay_on    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg.index)
                CFG_CORE_COUNT: r_core_count <= i_cfg.data;
                CFG_STAY_ON:    r_stay_on    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // event item
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_item) begin
            r_mode <= i_item.mode;
            r_id   <= i_item.unit_id;
        end
    end

    // marks, gating count, powered count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stp     <= '0;
            r_pool    <= '0;
            r_hold    <= '0;
            r_powered <= '0;
        end else if (is_op) begin
            if (uw.op == OP_DISPATCH) begin
                unique case (r_mode)
                    MODE_STP_EN:   r_stp  <= r_stp | id_bit;
                    MODE_STP_DIS:  r_stp  <= r_stp & ~id_bit;
                    MODE_POOL_EN:  r_pool <= r_pool | id_bit;
                    MODE_POOL_DIS: r_pool <= r_pool & ~id_bit;
                    default: ;
                endcase
            end
            if (uw.op == OP_HOLD && r_hold != HOLD_MAX) begin
                r_hold <= r_hold + 8'd1;
            end
            if (uw.op == OP_RELEASE && r_hold != 8'd0) begin
                r_hold <= r_hold - 8'd1;
            end
            if (uw.op == OP_EMIT && uw.upd == UPD_PWR_REQ) begin
                r_powered <= r_req;
            end
            if (uw.op == OP_EMIT && uw.upd == UPD_PWR_DN) begin
                r_powered <= na;
            end
        end
    end

    // loop registers
    always_ff @(posedge i_clk) begin
        if (is_op) begin
            if (uw.op == OP_DISPATCH) begin
                r_r <= r_powered;
            end
            if (uw.op == OP_WALK && !o_stat.walk_done) begin
                r_r <= r_r - 4'd1;
            end
            if (uw.op == OP_UPCHK) begin
                r_req <= req_up;
                r_a   <= r_powered;
            end
            if (uw.op == OP_DNCHK) begin
                r_req <= req_dn[3:0];
            end
            if (uw.op == OP_EMIT && uw.upd == UPD_A_INC) begin
                r_a <= r_a + 4'd2;
            end
        end
    end
endmodule

FILE: src/cpps_sequencer.sv
module cpps_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cpps_stream_if.sink      i_in,
    cpps_stream_if.source    o_out,
    input  cpps_pkg::t_stat  i_stat,
    output cpps_pkg::t_ctl   o_ctl
);
    import cpps_pkg::*;

    logic            r_busy;
    logic            n_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_pend_valid;
    logic            n_pend_valid;
    t_out_item       r_pend;
    t_out_item       n_pend;
    logic            r_out_valid;
    logic            n_out_valid;
    t_out_item       r_out;
    t_out_item       n_out;

    t_uword          uw;
    logic            take;
    logic            emit_now;
    logic            is_end;
    logic            need_move;
    logic            out_free;
    logic            fire;

    cpps_ucode_rom u_rom (
        .i_addr (r_pc),
        .o_word (uw)
    );

    assign take      = i_in.valid && !r_busy;
    assign is_end    = (uw.op == OP_END);
    assign emit_now  = (uw.op == OP_EMIT)
                     || (uw.op == OP_HOLD && i_stat.hold_zero)
                     || (uw.op == OP_RELEASE && i_stat.hold_le1);
    assign need_move = r_pend_valid && (emit_now || is_end);
    assign out_free  = !r_out_valid || o_out.ready;
    assign fire      = r_busy && !(need_move && !out_free);

    assign i_in.ready    = !r_busy;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign o_ctl.take_item = take;
    assign o_ctl.fire      = fire;
    assign o_ctl.uw        = uw;

    always_comb begin
        n_busy       = r_busy;
        n_pc         = r_pc;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (take) begin
            n_busy = 1'b1;
            n_pc   = L_DISP;
        end

        if (fire) begin
            // the held write moves out once we know whether it is the last
            if (need_move) begin
                n_out       = r_pend;
                n_out.last  = is_end;
                n_out_valid = 1'b1;
            end
            if (emit_now) begin
                n_pend.target  = uw.target;
                n_pend.action  = uw.action;
                n_pend.value   = i_stat.value;
                n_pend.wait_us = uw.wait_us;
                n_pend.last    = 1'b0;
                n_pend_valid   = 1'b1;
            end else if (is_end) begin
                n_pend_valid = 1'b0;
            end
            if (uw.op == OP_SETWAIT) begin
                n_pend.wait_us = WAIT_100;
            end

            unique case (uw.op)
                OP_END:      n_busy = 1'b0;
                OP_DISPATCH: n_pc = i_stat.disp_addr;
                OP_UPCHK,
                OP_DNCHK:    n_pc = i_stat.skip ? L_END : r_pc + 5'd1;
                OP_WALK:     n_pc = i_stat.walk_done ? r_pc + 5'd1 : r_pc;
                default: begin
                    unique case (uw.br)
                        BR_NEXT:    n_pc = r_pc + 5'd1;
                        BR_JUMP:    n_pc = uw.addr;
                        BR_LOOP_UP: n_pc = i_stat.loop_up ? uw.addr : r_pc + 5'd1;
                        BR_LOOP_DN: n_pc = i_stat.loop_dn ? uw.addr : r_pc + 5'd1;
                        default:    n_pc = r_pc + 5'd1;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pc         <= L_END;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_pc         <= n_pc;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end
endmodule

FILE: src/core_pair_power_sequencer.sv
// core-pair power sequencer: takes enable/disable events for stencil processors
// and line-buffer pools, and gating hold/release events, and answers with the
// ordered control-register writes that power core pairs up or down, each with
// its target, action, value (core mask or pair count) and the wait to observe
// after it. control is a 32-step microprogram in a rom; one step retires per
// cycle when the output side keeps up. an event that ends at its decode step (no
// power change or an unknown mode) runs only the mode decode step and the end
// step before the input is ready again. other events also run a step for each
// write they produce, their control steps, and a walk step for each unit
// checked when a disable searches down the enabled marks. each write is held in
// a pending register until the next write or the end step, so that its last
// flag and final wait are known before it goes out; a full output register
// stalls the step that would move a held write out. a new event is taken the
// cycle after the end step retires, while the final write may still wait in
// the output register. configuration writes are always accepted and take
// effect on the next edge.
module core_pair_power_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpps_stream_if.sink   i_in,
    cpps_stream_if.source o_out,
    cpps_stream_if.sink   i_cfg
);
    import cpps_pkg::*;

    // control word and strobes from the step counter to the datapath
    t_ctl  ctl;
    // branch conditions and write value back from the datapath
    t_stat stat;
    logic  in_xfer;

    // config registers have no side effects, so the port never stalls
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;

    cpps_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    cpps_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.payload),
        .i_ctl    (ctl),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.payload),
        .o_stat   (stat)
    );

    // an accepted event always starts with its decode step on the next cycle
    a_decode_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> ctl.fire && ctl.uw.op == OP_DISPATCH)
        else $error("event transfer not followed by decode step");

    // once the end step retires the block takes the next event
    a_ready_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.fire && ctl.uw.op == OP_END |=> i_in.ready)
        else $error("input not ready after end of program");

    // gating group writes carry no mask and only set or clear
    a_group_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.target == T_GROUP |->
            o_out.payload.value == 13'd0
            && (o_out.payload.action == ACT_SET || o_out.payload.action == ACT_CLEAR))
        else $error("malformed gating group write");
endmodule
